>>> design/jts_pkg.sv
// Shared types and token kind codes for the JSON token scanner.
`default_nettype none

package jts_pkg;

   // Scan modes of the tokenizer
   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_STR   = 3'd1,
      MODE_ESC   = 3'd2,
      MODE_NUM   = 3'd3,
      MODE_IDENT = 3'd4
   } scan_mode_type;

   // Token kinds carried on the result channel
   localparam logic [3:0] KIND_VALUE  = 4'd0;
   localparam logic [3:0] KIND_EQUAL  = 4'd1;
   localparam logic [3:0] KIND_COLON  = 4'd2;
   localparam logic [3:0] KIND_COMMA  = 4'd3;
   localparam logic [3:0] KIND_LBRACK = 4'd4;
   localparam logic [3:0] KIND_RBRACK = 4'd5;
   localparam logic [3:0] KIND_LBRACE = 4'd6;
   localparam logic [3:0] KIND_RBRACE = 4'd7;
   localparam logic [3:0] KIND_STRING = 4'd8;
   localparam logic [3:0] KIND_NUMBER = 4'd9;
   localparam logic [3:0] KIND_TRUE   = 4'd10;
   localparam logic [3:0] KIND_FALSE  = 4'd11;
   localparam logic [3:0] KIND_IDENT  = 4'd12;

   // Keyword match progress codes
   localparam logic [3:0] KW_NONE       = 4'd0;
   localparam logic [3:0] KW_TRUE_T     = 4'd1;
   localparam logic [3:0] KW_TRUE_DONE  = 4'd4;
   localparam logic [3:0] KW_FALSE_F    = 4'd5;
   localparam logic [3:0] KW_FALSE_DONE = 4'd9;

   // Most results one input word can cause
   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        end_of_text;
   } jts_req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] value_unit;
      logic        last_of_run;
   } jts_rsp_type;

endpackage

`default_nettype wire

>>> design/json_token_scanner.sv
// Streaming JSON token scanner: one 16-bit code unit in, zero to three tokens out.
//
// Usage:
//   req channel (req_valid / req_stall / req_data) takes one code unit per word,
//   with end_of_text marking the last unit of a text. rsp channel
//   (rsp_valid / rsp_stall / rsp_data) returns token words in order; the
//   last word caused by one input carries last_of_run.
//   The input word is scanned in the cycle it is accepted and its results land
//   in a three-entry result register, so the first result is shown in the cycle
//   after acceptance. An input that causes k results holds the result register
//   until all k have left, one result per cycle while rsp_stall is low.
//   A new input is taken in the same cycle as the last pending result leaves,
//   so a stream of words with at most one result each runs at one per cycle;
//   words with no result are absorbed at one per cycle as well.
//   When the receiver stalls, the current result holds and req_stall rises
//   once the result register cannot be emptied in that cycle.
//   Synchronous reset returns the scanner between tokens with no keyword
//   match and discards any pending results.
`default_nettype none

module json_token_scanner
   import jts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire jts_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output jts_rsp_type      rsp_data
);

   localparam logic [15:0] CH_QUOTE  = 16'h0022;
   localparam logic [15:0] CH_BSLASH = 16'h005C;
   localparam logic [15:0] CH_DOT    = 16'h002E;
   localparam logic [15:0] CH_PLUS   = 16'h002B;
   localparam logic [15:0] CH_MINUS  = 16'h002D;
   localparam logic [15:0] CH_UNDER  = 16'h005F;
   localparam logic [15:0] CH_DOLLAR = 16'h0024;
   localparam logic [15:0] CH_EQUAL  = 16'h003D;
   localparam logic [15:0] CH_COLON  = 16'h003A;
   localparam logic [15:0] CH_COMMA  = 16'h002C;
   localparam logic [15:0] CH_LBRACK = 16'h005B;
   localparam logic [15:0] CH_RBRACK = 16'h005D;
   localparam logic [15:0] CH_LBRACE = 16'h007B;
   localparam logic [15:0] CH_RBRACE = 16'h007D;
   localparam logic [15:0] CH_SPACE  = 16'h0020;
   localparam logic [15:0] CH_LOW_T  = 16'h0074;
   localparam logic [15:0] CH_LOW_F  = 16'h0066;

   function automatic logic is_digit(input logic [15:0] c);
      return (c >= 16'h0030) && (c <= 16'h0039);
   endfunction

   function automatic logic is_alpha(input logic [15:0] c);
      return ((c >= 16'h0061) && (c <= 16'h007A)) || ((c >= 16'h0041) && (c <= 16'h005A));
   endfunction

   function automatic logic is_space(input logic [15:0] c);
      return (c == CH_SPACE) || ((c >= 16'h0009) && (c <= 16'h000D));
   endfunction

   // Next expected keyword character for a match progress code
   function automatic logic [15:0] kw_next(input logic [3:0] p);
      logic [15:0] ch;
      case (p)
         4'd1:    ch = 16'h0072; // r
         4'd2:    ch = 16'h0075; // u
         4'd3:    ch = 16'h0065; // e
         4'd5:    ch = 16'h0061; // a
         4'd6:    ch = 16'h006C; // l
         4'd7:    ch = 16'h0073; // s
         4'd8:    ch = 16'h0065; // e
         default: ch = 16'h0000;
      endcase
      return ch;
   endfunction

   function automatic logic kw_open(input logic [3:0] p);
      return ((p >= 4'd1) && (p <= 4'd3)) || ((p >= 4'd5) && (p <= 4'd8));
   endfunction

   function automatic logic [3:0] ident_kind(input logic [3:0] p);
      logic [3:0] k;
      if (p == KW_TRUE_DONE) begin
         k = KIND_TRUE;
      end else if (p == KW_FALSE_DONE) begin
         k = KIND_FALSE;
      end else begin
         k = KIND_IDENT;
      end
      return k;
   endfunction

   scan_mode_type mode_ff, mode_in;
   logic [3:0]    kp_ff, kp_in;

   logic [3:0]    kind_ff  [MAX_RESULTS];
   logic [15:0]   value_ff [MAX_RESULTS];
   logic [3:0]    kind_in  [MAX_RESULTS];
   logic [15:0]   value_in [MAX_RESULTS];
   logic [1:0]    cnt_ff, cnt_in;
   logic [1:0]    idx_ff;

   logic          take;
   logic          rsp_take;
   logic          rsp_last;

   // Pending-result bookkeeping and handshakes
   assign rsp_valid = idx_ff < cnt_ff;
   assign rsp_last  = (idx_ff + 2'd1) == cnt_ff;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = rsp_valid && !(rsp_last && !rsp_stall);
   assign take      = req_valid && !req_stall;

   always_comb begin
      rsp_data.kind        = KIND_VALUE;
      rsp_data.value_unit  = '0;
      case (idx_ff)
         2'd0: begin
            rsp_data.kind       = kind_ff[0];
            rsp_data.value_unit = value_ff[0];
         end
         2'd1: begin
            rsp_data.kind       = kind_ff[1];
            rsp_data.value_unit = value_ff[1];
         end
         2'd2: begin
            rsp_data.kind       = kind_ff[2];
            rsp_data.value_unit = value_ff[2];
         end
         default: begin
            rsp_data.kind       = KIND_VALUE;
            rsp_data.value_unit = '0;
         end
      endcase
      rsp_data.last_of_run = rsp_last;
   end

   // Scan one input word: next mode, keyword progress and its results
   always_comb begin
      logic [15:0] c;
      logic        rescan;
      logic [1:0]  n;
      c       = req_data.code_unit;
      rescan  = 1'b0;
      n       = 2'd0;
      mode_in = mode_ff;
      kp_in   = kp_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         kind_in[i]  = KIND_VALUE;
         value_in[i] = '0;
      end

      // Continue the current token
      case (mode_ff)
         MODE_STR: begin
            if (c == CH_QUOTE) begin
               kind_in[n] = KIND_STRING;
               n          = n + 2'd1;
               mode_in    = MODE_IDLE;
            end else if (c == CH_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               value_in[n] = c;
               n           = n + 2'd1;
            end
         end
         MODE_ESC: begin
            value_in[n] = c;
            n           = n + 2'd1;
            mode_in     = MODE_STR;
         end
         MODE_NUM: begin
            if (is_digit(c) || (c == CH_DOT)) begin
               value_in[n] = c;
               n           = n + 2'd1;
            end else begin
               kind_in[n] = KIND_NUMBER;
               n          = n + 2'd1;
               rescan     = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_alpha(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_DOLLAR)) begin
               value_in[n] = c;
               n           = n + 2'd1;
               if (kw_open(kp_ff) && (c == kw_next(kp_ff))) begin
                  kp_in = kp_ff + 4'd1;
               end else begin
                  kp_in = KW_NONE;
               end
            end else begin
               kind_in[n] = ident_kind(kp_ff);
               n          = n + 2'd1;
               rescan     = 1'b1;
            end
         end
         default: begin
            rescan = 1'b1;
         end
      endcase

      // Start a new token with this unit
      if (rescan) begin
         mode_in = MODE_IDLE;
         kp_in   = KW_NONE;
         if (is_space(c)) begin
            mode_in = MODE_IDLE;
         end else if (c == CH_EQUAL) begin
            kind_in[n] = KIND_EQUAL;
            n          = n + 2'd1;
         end else if (c == CH_COLON) begin
            kind_in[n] = KIND_COLON;
            n          = n + 2'd1;
         end else if (c == CH_COMMA) begin
            kind_in[n] = KIND_COMMA;
            n          = n + 2'd1;
         end else if (c == CH_LBRACK) begin
            kind_in[n] = KIND_LBRACK;
            n          = n + 2'd1;
         end else if (c == CH_RBRACK) begin
            kind_in[n] = KIND_RBRACK;
            n          = n + 2'd1;
         end else if (c == CH_LBRACE) begin
            kind_in[n] = KIND_LBRACE;
            n          = n + 2'd1;
         end else if (c == CH_RBRACE) begin
            kind_in[n] = KIND_RBRACE;
            n          = n + 2'd1;
         end else if (c == CH_QUOTE) begin
            mode_in = MODE_STR;
         end else if (is_digit(c) || (c == CH_PLUS) || (c == CH_MINUS)) begin
            mode_in     = MODE_NUM;
            value_in[n] = c;
            n           = n + 2'd1;
         end else if (is_alpha(c)) begin
            mode_in     = MODE_IDENT;
            value_in[n] = c;
            n           = n + 2'd1;
            if (c == CH_LOW_T) begin
               kp_in = KW_TRUE_T;
            end else if (c == CH_LOW_F) begin
               kp_in = KW_FALSE_F;
            end else begin
               kp_in = KW_NONE;
            end
         end
      end

      // Flush the open token at end of text
      if (req_data.end_of_text) begin
         case (mode_in)
            MODE_STR, MODE_ESC: begin
               kind_in[n] = KIND_STRING;
               n          = n + 2'd1;
            end
            MODE_NUM: begin
               kind_in[n] = KIND_NUMBER;
               n          = n + 2'd1;
            end
            MODE_IDENT: begin
               kind_in[n] = ident_kind(kp_in);
               n          = n + 2'd1;
            end
            default: begin
               n = n;
            end
         endcase
         mode_in = MODE_IDLE;
         kp_in   = KW_NONE;
      end
      cnt_in = n;
   end

   // Control state: scan mode, keyword match, result count and read index
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         kp_ff   <= KW_NONE;
         cnt_ff  <= 2'd0;
         idx_ff  <= 2'd0;
      end else if (take) begin
         mode_ff <= mode_in;
         kp_ff   <= kp_in;
         cnt_ff  <= cnt_in;
         idx_ff  <= 2'd0;
      end else if (rsp_take) begin
         idx_ff  <= idx_ff + 2'd1;
      end
   end

   // Result register: load all results of an accepted word
   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            kind_ff[i]  <= kind_in[i];
            value_ff[i] <= value_in[i];
         end
      end
   end

   // Read index never passes the result count
   assert property (@(posedge clock) disable iff (reset) idx_ff <= cnt_ff)
      else $error("result index beyond result count");

   // Keyword progress lives only inside an identifier
   assert property (@(posedge clock) disable iff (reset)
      kp_ff != KW_NONE |-> mode_ff == MODE_IDENT)
      else $error("keyword progress outside identifier");

   // End of text leaves the scanner between tokens
   assert property (@(posedge clock) disable iff (reset)
      take && req_data.end_of_text |=> mode_ff == MODE_IDLE && kp_ff == KW_NONE)
      else $error("scanner not idle after end of text");

   // A non-final result taken is followed by another result
   assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_last |=> rsp_valid)
      else $error("result run cut short");

   // No input is taken while a non-final result is pending
   assert property (@(posedge clock) disable iff (reset)
      take |-> !rsp_valid || (rsp_last && rsp_take))
      else $error("input accepted over pending results");

endmodule

`default_nettype wire
